@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srf_pkg.sv @@
`default_nettype none
package srf_pkg;

  // Number formatting.
  localparam int MAX_DIGITS = 10;
  localparam int NUM_DIGITS = 10;               // digits of a 33-bit magnitude
  localparam int MAG_W      = 33;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int DAB_STEPS  = 3;                // shift-add-3 steps per cycle
  localparam int DAB_CYCLES = MAG_W / DAB_STEPS;
  localparam int DAB_CW     = $clog2(DAB_CYCLES + 1);
  localparam int DMAX       = (NUM_DIGITS > MAX_DIGITS) ? NUM_DIGITS : MAX_DIGITS;
  localparam int DCW        = $clog2(DMAX + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  // Field widths.
  localparam int CNT_W  = 30;
  localparam int OP_W   = 4;
  localparam int ERR_W  = 2;
  localparam int CFG_AW = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 30'd4096;
  localparam logic             REG_CAPACITY = 1'b0;

  // Characters.
  localparam logic [7:0] SEP_FS   = 8'h1c;
  localparam logic [7:0] SEP_GS   = 8'h1d;
  localparam logic [7:0] SEP_RS   = 8'h1e;
  localparam logic [7:0] SEP_US   = 8'h1f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Commands.
  localparam logic [OP_W-1:0] OP_START   = 4'd0;
  localparam logic [OP_W-1:0] OP_KEY     = 4'd1;
  localparam logic [OP_W-1:0] OP_TEXT    = 4'd2;
  localparam logic [OP_W-1:0] OP_RSTAT   = 4'd3;
  localparam logic [OP_W-1:0] OP_USNUM   = 4'd4;
  localparam logic [OP_W-1:0] OP_USEMPTY = 4'd5;
  localparam logic [OP_W-1:0] OP_STATUS  = 4'd6;
  localparam logic [OP_W-1:0] OP_STTEXT  = 4'd7;
  localparam logic [OP_W-1:0] OP_FIELD   = 4'd8;
  localparam logic [OP_W-1:0] OP_CLOSE   = 4'd9;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_SPACE = 2'd2;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef enum logic [2:0] {ACT_SEP, ACT_DATA, ACT_MINUS, ACT_CONV, ACT_DIGITS} act_t;
  typedef enum logic [1:0] {END_NO, END_YES, END_IF350} endc_t;

  typedef logic [4:0] step_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] lit;
    logic       sgn;
    logic       closing;
    endc_t      endc;
    step_t      nxt;
  } uword_t;

  typedef struct packed {
    logic             done;
    logic             nines;
    logic [DCW-1:0]   first;
    logic [BCD_W-1:0] bcd;
  } b2d_res_t;

  // Microprogram addresses.
  localparam step_t S_START      = 5'd0;
  localparam step_t S_START_CONV = 5'd1;
  localparam step_t S_START_DIG  = 5'd2;
  localparam step_t S_START_US   = 5'd3;
  localparam step_t S_KEY        = 5'd4;
  localparam step_t S_TEXT       = 5'd5;
  localparam step_t S_RS         = 5'd6;
  localparam step_t S_SIG_CONV   = 5'd7;
  localparam step_t S_SIG_MINUS  = 5'd8;
  localparam step_t S_SIG_DIG    = 5'd9;
  localparam step_t S_USN        = 5'd10;
  localparam step_t S_USN_CONV   = 5'd11;
  localparam step_t S_USN_DIG    = 5'd12;
  localparam step_t S_USE        = 5'd13;
  localparam step_t S_GS         = 5'd14;
  localparam step_t S_RS_TEXT    = 5'd15;
  localparam step_t S_FLD        = 5'd16;
  localparam step_t S_FLD_CONV   = 5'd17;
  localparam step_t S_FLD_MINUS  = 5'd18;
  localparam step_t S_FLD_DIG    = 5'd19;
  localparam step_t S_FLD_US     = 5'd20;
  localparam step_t S_CLOSE      = 5'd21;

  function automatic uword_t mk(act_t a, logic [7:0] l, logic s, logic c,
                                endc_t e, step_t n);
    uword_t w;
    w.act     = a;
    w.lit     = l;
    w.sgn     = s;
    w.closing = c;
    w.endc    = e;
    w.nxt     = n;
    return w;
  endfunction

  // Control store.
  function automatic uword_t ucode(step_t a);
    uword_t w;
    case (a)
      S_START:      w = mk(ACT_SEP,    SEP_FS,   1'b0, 1'b0, END_NO,    S_START_CONV);
      S_START_CONV: w = mk(ACT_CONV,   8'h00,    1'b0, 1'b0, END_NO,    S_START_DIG);
      S_START_DIG:  w = mk(ACT_DIGITS, 8'h00,    1'b0, 1'b0, END_IF350, S_START_US);
      S_START_US:   w = mk(ACT_SEP,    SEP_US,   1'b0, 1'b0, END_YES,   S_START);
      S_KEY:        w = mk(ACT_SEP,    SEP_GS,   1'b0, 1'b0, END_YES,   S_START);
      S_TEXT:       w = mk(ACT_DATA,   8'h00,    1'b0, 1'b0, END_YES,   S_START);
      S_RS:         w = mk(ACT_SEP,    SEP_RS,   1'b0, 1'b0, END_NO,    S_SIG_CONV);
      S_SIG_CONV:   w = mk(ACT_CONV,   8'h00,    1'b1, 1'b0, END_NO,    S_SIG_MINUS);
      S_SIG_MINUS:  w = mk(ACT_MINUS,  CH_MINUS, 1'b0, 1'b0, END_NO,    S_SIG_DIG);
      S_SIG_DIG:    w = mk(ACT_DIGITS, 8'h00,    1'b0, 1'b0, END_YES,   S_START);
      S_USN:        w = mk(ACT_SEP,    SEP_US,   1'b0, 1'b0, END_NO,    S_USN_CONV);
      S_USN_CONV:   w = mk(ACT_CONV,   8'h00,    1'b0, 1'b0, END_NO,    S_USN_DIG);
      S_USN_DIG:    w = mk(ACT_DIGITS, 8'h00,    1'b0, 1'b0, END_YES,   S_START);
      S_USE:        w = mk(ACT_SEP,    SEP_US,   1'b0, 1'b0, END_YES,   S_START);
      S_GS:         w = mk(ACT_SEP,    SEP_GS,   1'b0, 1'b0, END_NO,    S_SIG_CONV);
      S_RS_TEXT:    w = mk(ACT_SEP,    SEP_RS,   1'b0, 1'b0, END_YES,   S_START);
      S_FLD:        w = mk(ACT_SEP,    SEP_RS,   1'b0, 1'b0, END_NO,    S_FLD_CONV);
      S_FLD_CONV:   w = mk(ACT_CONV,   8'h00,    1'b1, 1'b0, END_NO,    S_FLD_MINUS);
      S_FLD_MINUS:  w = mk(ACT_MINUS,  CH_MINUS, 1'b0, 1'b0, END_NO,    S_FLD_DIG);
      S_FLD_DIG:    w = mk(ACT_DIGITS, 8'h00,    1'b0, 1'b0, END_NO,    S_FLD_US);
      S_FLD_US:     w = mk(ACT_SEP,    SEP_US,   1'b0, 1'b0, END_YES,   S_START);
      S_CLOSE:      w = mk(ACT_SEP,    SEP_FS,   1'b0, 1'b1, END_YES,   S_START);
      default:      w = mk(ACT_SEP,    8'h00,    1'b0, 1'b0, END_YES,   S_START);
    endcase
    return w;
  endfunction

  // Entry point of each command's routine.
  function automatic step_t op_entry(logic [OP_W-1:0] op);
    step_t s;
    case (op)
      OP_START:   s = S_START;
      OP_KEY:     s = S_KEY;
      OP_TEXT:    s = S_TEXT;
      OP_RSTAT:   s = S_RS;
      OP_USNUM:   s = S_USN;
      OP_USEMPTY: s = S_USE;
      OP_STATUS:  s = S_GS;
      OP_STTEXT:  s = S_RS_TEXT;
      OP_FIELD:   s = S_FLD;
      OP_CLOSE:   s = S_CLOSE;
      default:    s = S_START;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/srf_b2d.sv @@
`default_nettype none
// Binary to BCD converter, shift-add-3 with several steps per cycle.
module srf_b2d
  import srf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] mag,
  output b2d_res_t              res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DAB_CW-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [BCD_W-1:0]  b;
  logic [MAG_W-1:0]  m;
  logic [DCW-1:0]    hi;

  always_comb begin
    b = bcd_r;
    m = mag_r;
    for (int s = 0; s < DAB_STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DAB_CW'(DAB_CYCLES);
      mag_nxt  = mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = b;
      mag_nxt = m;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DAB_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Position of the leading nonzero digit; zero prints as a single digit.
  always_comb begin
    hi = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        hi = DCW'(i);
      end
    end
    res.done  = done_r;
    res.nines = (hi >= DCW'(MAX_DIGITS));
    res.first = res.nines ? DCW'(MAX_DIGITS - 1) : hi;
    res.bcd   = bcd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/separator_record_framer_unit.sv @@
`default_nettype none
// Separator record framer.
// Commands arrive on the in_ stream (in_tuser holds the command code, in_tdata
// the number and the text byte) and each one turns into a run of result items
// on the out_ stream, at most one message byte per item, the final item of a
// run flagged by out_tlast. A command that only raises or reports an error
// gives a single item with no byte. Capacity is set through the cfg_ APB port,
// to be written only while the block is idle; the block does not enforce this.
// Commands are handled one at a time by a small microprogram: one control
// word per step emits a separator, the text byte, a minus sign or the digits
// of a number, or runs the number's conversion. Plain bytes go out one per
// cycle while the output is not held. A numeric step first runs the binary to
// decimal converter, and a new command is accepted once the sequencer is idle
// again and the output register has room.
// The results pass through a single output register, which can take a new item
// in the same cycle the waiting one is accepted; when the receiver holds
// out_tready low the sequencer stalls on its next byte and nothing is dropped.
// Reset (rst_n low, synchronous) clears the counters, flags and error state,
// and sets the capacity back to 4096 bytes.
module separator_record_framer_unit
  import srf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [47:0]       in_tdata,   // number[32:0], data_byte[40:33], zero fill
  input  wire logic [3:0]        in_tuser,   // op[3:0]
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // out_byte[7:0], error[9:8], length[39:10]
  output logic [0:0]             out_tuser,  // byte_valid[0]
  output logic                   out_tlast,
  // Configuration port.
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  seq_state_t       state_r, state_nxt;
  step_t            step_r, step_nxt;
  logic             started_r, started_nxt;
  logic [DCW-1:0]   dig_r, dig_nxt;
  logic             nines_r, nines_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] num_r, num_nxt;
  logic [7:0]       db_r, db_nxt;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic             header_r, header_nxt;
  logic             closed_r, closed_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  logic             ov_r, ov_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             obv_r, obv_nxt;
  logic             olast_r, olast_nxt;
  logic [ERR_W-1:0] oerr_r, oerr_nxt;
  logic [CNT_W-1:0] olen_r, olen_nxt;

  uword_t           uw;
  b2d_res_t         conv;
  logic             conv_start;
  logic [MAG_W-1:0] conv_mag;
  logic             slot_free;
  logic             cfg_wr;
  logic [OP_W-1:0]  in_op;
  logic             single;
  logic [CNT_W-1:0] single_len;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             step_done;
  logic             fin;
  logic             is350;
  logic [CNT_W-1:0] bc_inc;

  srf_b2d u_b2d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (conv_mag),
    .res   (conv)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_CAPACITY);
  assign cfg_prdata = {2'b00, cap_r};

  assign slot_free = !ov_r || out_tready;
  assign in_tready = (state_r == SEQ_IDLE) && slot_free;
  assign in_op     = in_tuser;
  assign uw        = ucode(step_r);
  assign is350     = (num_r[31:0] == 32'd350);
  assign bc_inc    = bc_r + 1'b1;

  // Signed commands print the magnitude of the sign-extended 33-bit value.
  assign conv_mag = (uw.sgn && num_r[MAG_W-1]) ? (~num_r + 1'b1)
                                               : {1'b0, num_r[31:0]};

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    started_nxt = started_r;
    dig_nxt     = dig_r;
    nines_nxt   = nines_r;
    neg_nxt     = neg_r;
    num_nxt     = num_r;
    db_nxt      = db_r;
    bc_nxt      = bc_r;
    header_nxt  = header_r;
    closed_nxt  = closed_r;
    err_nxt     = err_r;
    ov_nxt      = ov_r && !out_tready;
    obyte_nxt   = obyte_r;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    olen_nxt    = olen_r;
    conv_start  = 1'b0;
    single      = 1'b0;
    single_len  = '0;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    step_done   = 1'b1;
    fin         = 1'b0;

    if (state_r == SEQ_IDLE) begin
      if (in_tvalid && in_tready) begin
        num_nxt = in_tdata[32:0];
        db_nxt  = in_tdata[40:33];
        if (err_r != ERR_NONE || in_op > OP_CLOSE) begin
          single = 1'b1;
        end else begin
          case (in_op)
            OP_START: begin
              bc_nxt     = '0;
              closed_nxt = 1'b0;
              header_nxt = 1'b1;
              state_nxt  = SEQ_RUN;
            end
            OP_TEXT, OP_FIELD: begin
              if (closed_r) begin
                err_nxt = ERR_INVALID;
                single  = 1'b1;
              end else begin
                if (in_op == OP_FIELD) begin
                  header_nxt = 1'b0;
                end
                state_nxt = SEQ_RUN;
              end
            end
            OP_CLOSE: begin
              header_nxt = 1'b0;
              if (closed_r) begin
                single     = 1'b1;
                single_len = bc_r;
              end else begin
                state_nxt = SEQ_RUN;
              end
            end
            default: begin
              if (!header_r) begin
                err_nxt = ERR_INVALID;
                single  = 1'b1;
              end else begin
                state_nxt = SEQ_RUN;
              end
            end
          endcase
        end
        step_nxt    = op_entry(in_op);
        started_nxt = 1'b0;
        if (single) begin
          ov_nxt    = 1'b1;
          obyte_nxt = 8'h00;
          obv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          oerr_nxt  = err_nxt;
          olen_nxt  = single_len;
        end
      end
    end else begin
      case (uw.act)
        ACT_CONV: begin
          if (!started_r) begin
            conv_start  = 1'b1;
            started_nxt = 1'b1;
            neg_nxt     = uw.sgn && num_r[MAG_W-1];
          end else if (conv.done) begin
            dig_nxt     = conv.first;
            nines_nxt   = conv.nines;
            started_nxt = 1'b0;
            step_nxt    = uw.nxt;
          end
        end
        ACT_MINUS: begin
          if (neg_r) begin
            emit      = slot_free;
            emit_byte = uw.lit;
          end else begin
            step_nxt = uw.nxt;
          end
        end
        ACT_DATA: begin
          emit      = slot_free;
          emit_byte = db_r;
        end
        ACT_DIGITS: begin
          emit      = slot_free;
          step_done = (dig_r == '0);
          emit_byte = nines_r ? CH_NINE
                              : CH_ZERO + {4'b0000, conv.bcd[{dig_r[IDX_W-1:0], 2'b00} +: 4]};
        end
        default: begin
          emit      = slot_free;
          emit_byte = uw.lit;
        end
      endcase

      fin = step_done && (uw.act != ACT_MINUS) &&
            ((uw.endc == END_YES) || ((uw.endc == END_IF350) && is350));

      if (emit) begin
        ov_nxt = 1'b1;
        if (bc_r >= cap_r) begin
          // Out of room: the run ends with an empty item carrying the error.
          err_nxt   = ERR_NO_SPACE;
          obyte_nxt = 8'h00;
          obv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          oerr_nxt  = ERR_NO_SPACE;
          olen_nxt  = '0;
          state_nxt = SEQ_IDLE;
        end else begin
          bc_nxt    = bc_inc;
          obyte_nxt = emit_byte;
          obv_nxt   = 1'b1;
          olast_nxt = fin;
          oerr_nxt  = err_r;
          olen_nxt  = (uw.closing && fin) ? bc_inc : '0;
          if (uw.closing) begin
            closed_nxt = 1'b1;
          end
          if (fin) begin
            state_nxt = SEQ_IDLE;
          end else if (step_done) begin
            step_nxt = uw.nxt;
          end else begin
            dig_nxt = dig_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SEQ_IDLE;
      step_r    <= S_START;
      started_r <= 1'b0;
      cap_r     <= CAP_RESET;
      bc_r      <= '0;
      header_r  <= 1'b0;
      closed_r  <= 1'b0;
      err_r     <= ERR_NONE;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      started_r <= started_nxt;
      if (cfg_wr) begin
        cap_r <= cfg_pwdata[CNT_W-1:0];
      end
      bc_r      <= bc_nxt;
      header_r  <= header_nxt;
      closed_r  <= closed_nxt;
      err_r     <= err_nxt;
      ov_r      <= ov_nxt;
    end
    dig_r   <= dig_nxt;
    nines_r <= nines_nxt;
    neg_r   <= neg_nxt;
    num_r   <= num_nxt;
    db_r    <= db_nxt;
    obyte_r <= obyte_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    olen_r  <= olen_nxt;
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = {olen_r, oerr_r, obyte_r};
  assign out_tuser[0] = obv_r;
  assign out_tlast    = olast_r;

`include "assert_macros.svh"

  // A message byte never pushes the count past the capacity.
  `ASSERT_SAME(a_count_in_cap, clk, rst_n, ov_r && obv_r, bc_r <= cap_r, "byte count past capacity")
  // An item that reports an error carries no message byte.
  `ASSERT_SAME(a_err_no_byte, clk, rst_n, ov_r && (oerr_r != ERR_NONE), !obv_r, "error item with byte")
  // Errors stay until reset.
  `ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r != ERR_NONE, err_r == $past(err_r), "error changed")
  // The converter is started only from a conversion step of a running command.
  `ASSERT_SAME(a_conv_start, clk, rst_n, conv_start,
               (state_r == SEQ_RUN) && (uw.act == ACT_CONV), "stray conversion start")

endmodule
`default_nettype wire
